// ===== rtl/tlfs_pkg.sv =====
package tlfs_pkg;

    localparam int MAX_TASKS = 16;
    localparam int SLOT_W    = 4;
    localparam int CNT_W     = 5;
    localparam int SLICE_W   = 8;

    localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;
    localparam logic [SLICE_W-1:0] SLICE_ONE   = 8'd1;
    localparam logic [CNT_W-1:0]   CNT_ONE     = 5'd1;
    localparam logic [CNT_W-1:0]   CNT_ZERO    = 5'd0;
    localparam logic [SLOT_W-1:0]  SLOT_ZERO   = 4'd0;

    typedef enum logic [1:0] {
        FUNC_ENQ  = 2'd0,
        FUNC_DEQ  = 2'd1,
        FUNC_TICK = 2'd2,
        FUNC_PICK = 2'd3
    } func_t;

    typedef struct packed {
        func_t             func;
        logic [SLOT_W-1:0] task_id;
        logic              task_level;
        logic              prev_running;
    } item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] next_task;
        logic              resched_req;
        logic [CNT_W-1:0]  running_count;
    } result_t;

endpackage

// ===== rtl/tlfs_sched_state.sv =====
module tlfs_sched_state (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            commit,
    input  tlfs_pkg::item_t                 item,
    input  logic [tlfs_pkg::SLICE_W-1:0]    time_slice,
    output tlfs_pkg::result_t               res
);

    localparam int NT = tlfs_pkg::MAX_TASKS;
    localparam int SW = tlfs_pkg::SLOT_W;
    localparam int CW = tlfs_pkg::CNT_W;
    localparam int LW = tlfs_pkg::SLICE_W;

    logic          level_reg  [NT];
    logic          level_next [NT];
    logic [LW-1:0] slice_reg  [NT];
    logic [LW-1:0] slice_next [NT];
    logic [SW-1:0] lnext_reg  [NT];
    logic [SW-1:0] lnext_next [NT];
    logic [SW-1:0] lprev_reg  [NT];
    logic [SW-1:0] lprev_next [NT];
    logic          queued_reg  [NT];
    logic          queued_next [NT];
    logic          qof_reg  [NT];
    logic          qof_next [NT];
    logic [SW-1:0] head_reg  [2];
    logic [SW-1:0] head_next [2];
    logic [SW-1:0] tail_reg  [2];
    logic [SW-1:0] tail_next [2];
    logic [CW-1:0] count_reg  [2];
    logic [CW-1:0] count_next [2];

    always_comb
    begin
        logic [SW-1:0] t;
        logic          uq;
        logic          aq;
        logic          do_unlink;
        logic          do_append;
        logic [SW-1:0] p;
        logic [SW-1:0] n;
        logic [SW-1:0] tl;

        level_next  = level_reg;
        slice_next  = slice_reg;
        lnext_next  = lnext_reg;
        lprev_next  = lprev_reg;
        queued_next = queued_reg;
        qof_next    = qof_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;

        t         = item.task_id;
        do_unlink = 1'b0;
        do_append = 1'b0;
        aq        = item.task_level;
        res.next_task   = tlfs_pkg::SLOT_ZERO;
        res.resched_req = 1'b0;

        unique case (item.func)
            tlfs_pkg::FUNC_ENQ:
            begin
                if (!queued_reg[t])
                begin
                    do_append     = 1'b1;
                    aq            = item.task_level;
                    level_next[t] = item.task_level;
                end
            end
            tlfs_pkg::FUNC_DEQ:
            begin
                do_unlink = queued_reg[t];
            end
            tlfs_pkg::FUNC_TICK:
            begin
                if (slice_reg[t] <= tlfs_pkg::SLICE_ONE)
                begin
                    res.resched_req = 1'b1;
                    slice_next[t]   = time_slice;
                    level_next[t]   = 1'b1;
                end
                else
                begin
                    slice_next[t] = slice_reg[t] - tlfs_pkg::SLICE_ONE;
                end
            end
            tlfs_pkg::FUNC_PICK:
            begin
                do_unlink = item.prev_running && queued_reg[t];
                do_append = item.prev_running;
                aq        = level_reg[t];
            end
        endcase

        // unlink first; a requeue on pick then appends to the updated lists
        if (do_unlink)
        begin
            uq = qof_reg[t];
            p  = lprev_reg[t];
            n  = lnext_reg[t];
            if (head_next[uq] == t)
                head_next[uq] = n;
            else
                lnext_next[p] = n;
            if (tail_next[uq] == t)
                tail_next[uq] = p;
            else
                lprev_next[n] = p;
            if (count_next[uq] != tlfs_pkg::CNT_ZERO)
                count_next[uq] = count_next[uq] - tlfs_pkg::CNT_ONE;
            queued_next[t] = 1'b0;
        end
        else
        begin
            uq = 1'b0;
            p  = tlfs_pkg::SLOT_ZERO;
            n  = tlfs_pkg::SLOT_ZERO;
        end

        if (do_append)
        begin
            tl = tail_next[aq];
            if (count_next[aq] == tlfs_pkg::CNT_ZERO)
            begin
                head_next[aq] = t;
                lprev_next[t] = tlfs_pkg::SLOT_ZERO;
            end
            else
            begin
                lnext_next[tl] = t;
                lprev_next[t]  = tl;
            end
            lnext_next[t]  = tlfs_pkg::SLOT_ZERO;
            tail_next[aq]  = t;
            count_next[aq] = count_next[aq] + tlfs_pkg::CNT_ONE;
            queued_next[t] = 1'b1;
            qof_next[t]    = aq;
        end
        else
        begin
            tl = tlfs_pkg::SLOT_ZERO;
        end

        if (item.func == tlfs_pkg::FUNC_PICK)
        begin
            if (count_next[0] != tlfs_pkg::CNT_ZERO)
                res.next_task = head_next[0];
            else if (count_next[1] != tlfs_pkg::CNT_ZERO)
                res.next_task = head_next[1];
            else
                res.next_task = t;
        end

        res.running_count = count_next[0] + count_next[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NT; i++)
            begin
                level_reg[i]  <= 1'b0;
                slice_reg[i]  <= tlfs_pkg::SLICE_RESET;
                queued_reg[i] <= 1'b0;
                qof_reg[i]    <= 1'b0;
            end
            for (int q = 0; q < 2; q++)
            begin
                head_reg[q]  <= tlfs_pkg::SLOT_ZERO;
                tail_reg[q]  <= tlfs_pkg::SLOT_ZERO;
                count_reg[q] <= tlfs_pkg::CNT_ZERO;
            end
        end
        else if (commit)
        begin
            level_reg  <= level_next;
            slice_reg  <= slice_next;
            queued_reg <= queued_next;
            qof_reg    <= qof_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
        end
    end

    // link words hold no meaning until written
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            lnext_reg <= lnext_next;
            lprev_reg <= lprev_next;
        end
    end

endmodule

// ===== rtl/two_level_feedback_scheduler_core.sv =====
// Pipeline: input register, then result register.
// Throughput: one beat per cycle unless out_stall holds; all queue updates for an item
// settle in combinational logic over the 16-slot link flops between the two registers.
// Reset (rst_n low, async): queues empty, levels 0, slices and time_slice at 10,
// both pipeline registers empty. Link words are left unset.
module two_level_feedback_scheduler_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [tlfs_pkg::SLICE_W-1:0]      cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        func,
    input  logic [tlfs_pkg::SLOT_W-1:0]       task_id,
    input  logic                              task_level,
    input  logic                              prev_running,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tlfs_pkg::SLOT_W-1:0]       next_task,
    output logic                              resched_req,
    output logic [tlfs_pkg::CNT_W-1:0]        running_count
);

    logic [tlfs_pkg::SLICE_W-1:0] time_slice_reg;
    logic                         s1_valid_reg;
    tlfs_pkg::item_t              s1_item_reg;
    logic                         out_valid_reg;
    tlfs_pkg::result_t            out_res_reg;
    tlfs_pkg::result_t            res;
    logic                         advance;
    logic                         in_take;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    tlfs_sched_state u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .commit     (advance),
        .item       (s1_item_reg),
        .time_slice (time_slice_reg),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_slice_reg <= tlfs_pkg::SLICE_RESET;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                time_slice_reg <= cfg_wr_data;
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg.func         <= tlfs_pkg::func_t'(func);
            s1_item_reg.task_id      <= task_id;
            s1_item_reg.task_level   <= task_level;
            s1_item_reg.prev_running <= prev_running;
        end
        if (advance)
            out_res_reg <= res;
    end

    assign out_valid     = out_valid_reg;
    assign next_task     = out_res_reg.next_task;
    assign resched_req   = out_res_reg.resched_req;
    assign running_count = out_res_reg.running_count;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int WATCHDOG_LIMIT = 2000;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_wr_en = 1'b0;
    logic [tlfs_pkg::SLICE_W-1:0] cfg_wr_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [1:0]                   func = '0;
    logic [tlfs_pkg::SLOT_W-1:0]  task_id = '0;
    logic                         task_level = 1'b0;
    logic                         prev_running = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [tlfs_pkg::SLOT_W-1:0]  next_task;
    logic                         resched_req;
    logic [tlfs_pkg::CNT_W-1:0]   running_count;

    // scheduler state as the block should hold it
    logic [tlfs_pkg::SLICE_W-1:0] m_slice_cfg;
    logic                         m_level [tlfs_pkg::MAX_TASKS];
    logic [tlfs_pkg::SLICE_W-1:0] m_slice_left [tlfs_pkg::MAX_TASKS];
    logic [tlfs_pkg::SLOT_W-1:0]  m_next [tlfs_pkg::MAX_TASKS];
    logic [tlfs_pkg::SLOT_W-1:0]  m_prev [tlfs_pkg::MAX_TASKS];
    logic                         m_queued [tlfs_pkg::MAX_TASKS];
    logic                         m_queue_sel [tlfs_pkg::MAX_TASKS];
    logic [tlfs_pkg::SLOT_W-1:0]  m_head [2];
    logic [tlfs_pkg::SLOT_W-1:0]  m_tail [2];
    logic [tlfs_pkg::CNT_W-1:0]   m_count [2];
    logic [tlfs_pkg::CNT_W-1:0]   m_total;

    tlfs_pkg::result_t            sched_outcomes [$];
    logic [tlfs_pkg::SLOT_W-1:0]  last_pick = '0;
    logic [tlfs_pkg::SLICE_W-1:0] random_slice = '0;
    bit                           idle_en = 1'b1;
    int                           errors = 0;
    int                           ops_sent = 0;
    int                           results_checked = 0;
    int                           expiries = 0;
    int                           quiet_cycles = 0;
    int                           stall_left = 0;

    two_level_feedback_scheduler_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .task_id       (task_id),
        .task_level    (task_level),
        .prev_running  (prev_running),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .next_task     (next_task),
        .resched_req   (resched_req),
        .running_count (running_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void sched_reset();
        m_slice_cfg = tlfs_pkg::SLICE_RESET;
        for (int i = 0; i < tlfs_pkg::MAX_TASKS; i++)
        begin
            m_level[i]      = 1'b0;
            m_slice_left[i] = tlfs_pkg::SLICE_RESET;
            m_next[i]       = tlfs_pkg::SLOT_ZERO;
            m_prev[i]       = tlfs_pkg::SLOT_ZERO;
            m_queued[i]     = 1'b0;
            m_queue_sel[i]  = 1'b0;
        end
        for (int q = 0; q < 2; q++)
        begin
            m_head[q]  = tlfs_pkg::SLOT_ZERO;
            m_tail[q]  = tlfs_pkg::SLOT_ZERO;
            m_count[q] = tlfs_pkg::CNT_ZERO;
        end
        m_total = tlfs_pkg::CNT_ZERO;
    endfunction

    function automatic void unlink_task(logic [tlfs_pkg::SLOT_W-1:0] t);
        logic                        q;
        logic [tlfs_pkg::SLOT_W-1:0] p;
        logic [tlfs_pkg::SLOT_W-1:0] n;
        q = m_queue_sel[t];
        p = m_prev[t];
        n = m_next[t];
        if (m_head[q] == t)
            m_head[q] = n;
        else
            m_next[p] = n;
        if (m_tail[q] == t)
            m_tail[q] = p;
        else
            m_prev[n] = p;
        if (m_count[q] != tlfs_pkg::CNT_ZERO)
            m_count[q] = m_count[q] - tlfs_pkg::CNT_ONE;
        m_queued[t] = 1'b0;
        m_total = m_count[0] + m_count[1];
    endfunction

    function automatic void append_task(logic [tlfs_pkg::SLOT_W-1:0] t, logic q);
        if (m_count[q] == tlfs_pkg::CNT_ZERO)
        begin
            m_head[q] = t;
            m_prev[t] = tlfs_pkg::SLOT_ZERO;
        end
        else
        begin
            m_next[m_tail[q]] = t;
            m_prev[t] = m_tail[q];
        end
        m_next[t]      = tlfs_pkg::SLOT_ZERO;
        m_tail[q]      = t;
        m_count[q]     = m_count[q] + tlfs_pkg::CNT_ONE;
        m_queued[t]    = 1'b1;
        m_queue_sel[t] = q;
        m_total = m_count[0] + m_count[1];
    endfunction

    function automatic tlfs_pkg::result_t sched_step(tlfs_pkg::func_t f,
                                                     logic [tlfs_pkg::SLOT_W-1:0] t,
                                                     logic lvl, logic prun);
        tlfs_pkg::result_t r;
        r = '0;
        case (f)
            tlfs_pkg::FUNC_ENQ:
            begin
                if (!m_queued[t])
                begin
                    m_level[t] = lvl;
                    append_task(t, lvl);
                end
            end
            tlfs_pkg::FUNC_DEQ:
            begin
                if (m_queued[t])
                    unlink_task(t);
            end
            tlfs_pkg::FUNC_TICK:
            begin
                // expiry reloads from the current register and demotes to level 1
                if (m_slice_left[t] <= tlfs_pkg::SLICE_ONE)
                begin
                    r.resched_req   = 1'b1;
                    m_slice_left[t] = m_slice_cfg;
                    m_level[t]      = 1'b1;
                end
                else
                    m_slice_left[t] = m_slice_left[t] - tlfs_pkg::SLICE_ONE;
            end
            default:
            begin
                if (prun)
                begin
                    if (m_queued[t])
                        unlink_task(t);
                    append_task(t, m_level[t]);
                end
                if (m_count[0] != tlfs_pkg::CNT_ZERO)
                    r.next_task = m_head[0];
                else if (m_count[1] != tlfs_pkg::CNT_ZERO)
                    r.next_task = m_head[1];
                else
                    r.next_task = t;
            end
        endcase
        r.running_count = m_total;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        errors++;
        $display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
    endtask

    // called just after a falling edge, returns just after the falling edge past the beat
    task automatic send_op(tlfs_pkg::func_t f, logic [tlfs_pkg::SLOT_W-1:0] t, logic lvl,
                           logic prun);
        tlfs_pkg::result_t r;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        task_id      <= t;
        task_level   <= lvl;
        prev_running <= prun;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = sched_step(f, t, lvl, prun);
        sched_outcomes.push_back(r);
        if (f == tlfs_pkg::FUNC_PICK)
            last_pick = r.next_task;
        if (r.resched_req)
            expiries++;
        ops_sent++;
        @(negedge clk);
    endtask

    task automatic write_time_slice(logic [tlfs_pkg::SLICE_W-1:0] v);
        in_valid <= 1'b0;
        while (sched_outcomes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        m_slice_cfg = v;
    endtask

    task automatic run_random_ops(int count, int enq_pct);
        int                          roll;
        logic [tlfs_pkg::SLOT_W-1:0] t;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            t = 4'($urandom_range(0, tlfs_pkg::MAX_TASKS - 1));
            if (roll < enq_pct)
                send_op(tlfs_pkg::FUNC_ENQ, t, 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
            else if (roll < enq_pct + 20)
                send_op(tlfs_pkg::FUNC_DEQ, t, 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
            else if (roll < enq_pct + 45)
            begin
                // mostly tick the task that is running, like a real timer would
                if ($urandom_range(0, 1) != 0)
                    t = last_pick;
                send_op(tlfs_pkg::FUNC_TICK, t, 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
            end
            else
            begin
                if ($urandom_range(0, 2) != 0)
                    t = last_pick;
                send_op(tlfs_pkg::FUNC_PICK, t, 1'($urandom_range(0, 1)),
                        $urandom_range(0, 3) != 0);
            end
        end
    endtask

    task automatic test_empty_block();
        send_op(tlfs_pkg::FUNC_PICK, 4'd6, 1'b0, 1'b0);   // nothing queued: falls back to prev
        send_op(tlfs_pkg::FUNC_DEQ, 4'd4, 1'b1, 1'b0);    // not queued, ignored
        send_op(tlfs_pkg::FUNC_TICK, 4'd4, 1'b0, 1'b0);   // ticks an unqueued task
        send_op(tlfs_pkg::FUNC_PICK, 4'd4, 1'b1, 1'b1);   // runnable unqueued prev gets appended
        send_op(tlfs_pkg::FUNC_DEQ, 4'd4, 1'b0, 1'b0);
    endtask

    task automatic test_fill_and_unlink();
        for (int i = 0; i < tlfs_pkg::MAX_TASKS; i++)
            send_op(tlfs_pkg::FUNC_ENQ, i[tlfs_pkg::SLOT_W-1:0], i[0], 1'b1);
        send_op(tlfs_pkg::FUNC_ENQ, 4'd5, 1'b0, 1'b0);    // already queued, level stays
        send_op(tlfs_pkg::FUNC_DEQ, 4'd7, 1'b0, 1'b1);    // middle of low queue
        send_op(tlfs_pkg::FUNC_DEQ, 4'd0, 1'b1, 1'b0);    // head of high queue
        send_op(tlfs_pkg::FUNC_DEQ, 4'd15, 1'b0, 1'b0);   // tail of low queue
        send_op(tlfs_pkg::FUNC_DEQ, 4'd7, 1'b0, 1'b0);    // already gone
        send_op(tlfs_pkg::FUNC_PICK, 4'd3, 1'b0, 1'b1);   // queued prev moves to its tail
        send_op(tlfs_pkg::FUNC_PICK, 4'd9, 1'b1, 1'b0);
    endtask

    task automatic test_slice_settings();
        write_time_slice(8'd1);
        run_random_ops(100, 30);
        write_time_slice(8'd255);
        run_random_ops(80, 50);
        idle_en = 1'b0;
        write_time_slice(8'd0);
        run_random_ops(80, 30);
        idle_en = 1'b1;
        write_time_slice(8'd2);
        run_random_ops(120, 25);
        write_time_slice(8'd3);
        run_random_ops(120, 35);
        random_slice = 8'($urandom_range(1, 255));
        write_time_slice(random_slice);
        run_random_ops(100, 30);
    endtask

    task automatic test_final_stretch();
        idle_en = 1'b0;
        write_time_slice(8'd4);
        run_random_ops(150, 30);
    endtask

    // receiver side back-pressure in bursts
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idle_en && $urandom_range(0, 7) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 14);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        tlfs_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (sched_outcomes.size() == 0)
                report_mismatch("unexpected result beat, next_task", 8'(next_task), 8'd0);
            else
            begin
                want = sched_outcomes.pop_front();
                if (next_task !== want.next_task)
                    report_mismatch("next_task", 8'(next_task), 8'(want.next_task));
                if (resched_req !== want.resched_req)
                    report_mismatch("resched_req", 8'(resched_req), 8'(want.resched_req));
                if (running_count !== want.running_count)
                    report_mismatch("running_count", 8'(running_count),
                                    8'(want.running_count));
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                         quiet_cycles, sched_outcomes.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        sched_reset();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_empty_block();
        test_fill_and_unlink();
        test_slice_settings();
        test_final_stretch();
        in_valid <= 1'b0;
        while (sched_outcomes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("Covered %0d scheduler ops, %0d result beats checked, %0d slice expiries",
                 ops_sent, results_checked, expiries);
        $display("Slice settings 10, 1, 255, 0, 2, 3, %0d and 4, with and without stalls",
                 random_slice);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tlfs_pkg.sv
rtl/tlfs_sched_state.sv
rtl/two_level_feedback_scheduler_core.sv
test/testbench.sv
